// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL file of the septet packer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a non-overlapping implication outside of reset.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/gsp_pkg.sv =====
// Types and constants of the GSM septet packer.
package gsp_pkg;

  localparam int unsigned SeptetWidth = 7;
  localparam int unsigned OctetWidth  = 8;
  localparam logic [7:0]  MaxSeptets  = 8'd160;
  localparam logic [7:0]  LimitReset  = 8'd141;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrWidth  = $clog2(FifoDepth);
  localparam int unsigned CntWidth  = $clog2(FifoDepth + 1);

  typedef enum logic {
    RegFillBits   = 1'b0,
    RegOctetLimit = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] octet;
    logic       octet_valid;
    logic       end_of_message;
    logic [7:0] octet_count;
    logic       truncated;
  } result_t;

endpackage

// ===== src/gsm_septet_packer.sv =====
// Top level of the GSM septet packer: septet-to-octet packing with an output queue.
// Each result is registered into the output queue when its septet request is accepted.
// Throughput: one septet per cycle while at most two results are queued; one octet per taken cycle.
// A last septet that yields two octets holds two queue slots and is read out as two results.
// Reset (asynchronous, active low) starts a fresh message, empties the queue,
// and sets fill_bits to 0 and octet_limit to 141.
`include "assert_macros.svh"

module gsm_septet_packer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream: tdata[6:0] septet, tdata[7] zero; tlast is last_septet.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  // Output stream: tdata[7:0] octet, tdata[15:8] octet_count; tlast is end_of_message.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast,
  // tuser[0] octet_valid, tuser[1] truncated.
  output logic [1:0]  m_axis_tuser,
  // Configuration writes.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import gsp_pkg::*;

  logic [2:0] fill_bits_q;
  logic [7:0] octet_limit_q;

  logic [6:0] residual_bits_q, residual_bits_d;
  logic [2:0] residual_count_q, residual_count_d;
  logic       first_pending_q, first_pending_d;
  logic [7:0] septets_seen_q, septets_seen_d;
  logic [7:0] octets_sent_q, octets_sent_d;
  logic       overflow_q, overflow_d;

  result_t              fifo_q [FifoDepth];
  logic [PtrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]  count_q;

  logic       in_acc, out_acc;
  logic [6:0] sep;
  logic [6:0] rb, new_rb;
  logic [2:0] rc, new_rc;
  logic       sep_ok, full, emit1, emit2, flush_try;
  logic       ovf1, ovf2;
  logic [7:0] cnt1, cnt2;
  logic [13:0] acc;
  logic [7:0] done_oct, flush_oct;
  result_t    res_a, res_b;
  logic       push_a, push_b;
  logic [1:0] n_push;

  assign in_acc      = s_axis_tvalid && s_axis_tready;
  assign out_acc     = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign sep         = s_axis_tdata[SeptetWidth-1:0];

  always_comb begin
    rb        = first_pending_q ? '0 : residual_bits_q;
    rc        = first_pending_q ? fill_bits_q : residual_count_q;
    sep_ok    = septets_seen_q < MaxSeptets;
    acc       = 14'(rb) | (14'(sep) << rc);
    full      = sep_ok && (rc != 3'd0);
    done_oct  = acc[7:0];
    if (full) begin
      new_rb = {1'b0, acc[13:8]};
      new_rc = rc - 3'd1;
    end else if (sep_ok) begin
      new_rb = acc[6:0];
      new_rc = 3'd7;
    end else begin
      new_rb = rb;
      new_rc = rc;
    end
    flush_oct = {1'b0, new_rb};
    emit1     = full && (octets_sent_q < octet_limit_q);
    cnt1      = octets_sent_q + 8'(emit1);
    ovf1      = overflow_q | ~sep_ok | (full & ~emit1);
    flush_try = new_rc != 3'd0;
    emit2     = flush_try && (cnt1 < octet_limit_q);
    cnt2      = cnt1 + 8'(emit2);
    ovf2      = ovf1 | (flush_try & ~emit2);

    res_a = '{octet: done_oct, octet_valid: 1'b1, end_of_message: 1'b0,
              octet_count: cnt1, truncated: ovf1};
    res_b = res_a;
    push_a = 1'b0;
    push_b = 1'b0;
    if (!s_axis_tlast) begin
      push_a = emit1;
    end else if (emit1 && emit2) begin
      push_a = 1'b1;
      push_b = 1'b1;
      res_b  = '{octet: flush_oct, octet_valid: 1'b1, end_of_message: 1'b1,
                 octet_count: cnt2, truncated: ovf2};
    end else if (emit1) begin
      push_a = 1'b1;
      res_a.end_of_message = 1'b1;
      res_a.truncated      = ovf2;
    end else if (emit2) begin
      push_a = 1'b1;
      res_a  = '{octet: flush_oct, octet_valid: 1'b1, end_of_message: 1'b1,
                 octet_count: cnt2, truncated: ovf2};
    end else begin
      push_a = 1'b1;
      res_a  = '{octet: '0, octet_valid: 1'b0, end_of_message: 1'b1,
                 octet_count: cnt2, truncated: ovf2};
    end
    push_a = push_a && in_acc;
    push_b = push_b && in_acc;
    n_push = {1'b0, push_a} + {1'b0, push_b};

    if (s_axis_tlast) begin
      residual_bits_d  = '0;
      residual_count_d = '0;
      first_pending_d  = 1'b1;
      septets_seen_d   = '0;
      octets_sent_d    = '0;
      overflow_d       = 1'b0;
    end else begin
      residual_bits_d  = new_rb;
      residual_count_d = new_rc;
      first_pending_d  = 1'b0;
      septets_seen_d   = septets_seen_q + 8'(sep_ok);
      octets_sent_d    = cnt1;
      overflow_d       = ovf1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_bits_q      <= '0;
      octet_limit_q    <= LimitReset;
      residual_bits_q  <= '0;
      residual_count_q <= '0;
      first_pending_q  <= 1'b1;
      septets_seen_q   <= '0;
      octets_sent_q    <= '0;
      overflow_q       <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_reg_e'(cfg_index_i))
          RegFillBits:   fill_bits_q   <= cfg_data_i[2:0];
          RegOctetLimit: octet_limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        residual_bits_q  <= residual_bits_d;
        residual_count_q <= residual_count_d;
        first_pending_q  <= first_pending_d;
        septets_seen_q   <= septets_seen_d;
        octets_sent_q    <= octets_sent_d;
        overflow_q       <= overflow_d;
      end
    end
  end

  // Output queue: up to two results written per request, one read per cycle while the output is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrWidth'(n_push);
      rd_ptr_q <= rd_ptr_q + PtrWidth'(out_acc);
      count_q  <= count_q + CntWidth'(n_push) - CntWidth'(out_acc);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a) begin
      fifo_q[wr_ptr_q] <= res_a;
    end
    if (push_b) begin
      fifo_q[wr_ptr_q + PtrWidth'(1)] <= res_b;
    end
  end

  assign s_axis_tready = count_q <= CntWidth'(FifoDepth - 2);
  assign m_axis_tvalid = count_q != '0;
  assign m_axis_tdata  = {fifo_q[rd_ptr_q].octet_count, fifo_q[rd_ptr_q].octet};
  assign m_axis_tlast  = fifo_q[rd_ptr_q].end_of_message;
  assign m_axis_tuser  = {fifo_q[rd_ptr_q].truncated, fifo_q[rd_ptr_q].octet_valid};

  `ASSERT_CLK(a_count_bound, count_q <= CntWidth'(FifoDepth), "Output queue overfilled.")
  `ASSERT_CLK(a_septets_bound, septets_seen_q <= MaxSeptets, "Septet count beyond maximum.")
  `ASSERT_NEXT(a_last_restarts, in_acc && s_axis_tlast, first_pending_q,
               "Message state not cleared after last septet.")
  `ASSERT_NEXT(a_push_shows, in_acc && (n_push != 2'd0), m_axis_tvalid,
               "Result request missing after accepted septet.")

endmodule

// ===== tb/tb_gsm_septet_packer.sv =====
// Testbench for the GSM septet packer: directed and random messages checked against a predictor.
`timescale 1ns / 100ps

module tb_gsm_septet_packer;
  import gsp_pkg::*;

  class packer_model;
    logic [2:0]  fill;
    logic [7:0]  limit;
    logic [6:0]  res_bits;
    int          res_cnt;
    bit          first_pending;
    logic [7:0]  seen;
    logic [7:0]  sent;
    bit          ovf;
    result_t     expected_octets[$];
    int          errors;
    int          septets;
    int          results;
    int          messages;
    int          truncated_msgs;

    function new();
      fill = 3'd0;
      limit = LimitReset;
      res_bits = '0;
      res_cnt = 0;
      first_pending = 1'b1;
      seen = '0;
      sent = '0;
      ovf = 1'b0;
      errors = 0;
      septets = 0;
      results = 0;
      messages = 0;
      truncated_msgs = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [7:0] val);
      case (idx)
        RegFillBits:   fill = val[2:0];
        RegOctetLimit: limit = val;
        default: ;
      endcase
    endfunction

    function bit emit_ok();
      if (sent < limit) begin
        sent = sent + 8'd1;
        return 1'b1;
      end
      ovf = 1'b1;
      return 1'b0;
    endfunction

    function int pending();
      return expected_octets.size();
    endfunction

    function void accept_septet(logic [6:0] sep, logic last);
      logic [14:0] acc;
      int          bits;
      bit          have_done;
      bit          have_flush;
      logic [6:0]  flush_oct;
      result_t     done_r;
      result_t     r;
      have_done = 1'b0;
      have_flush = 1'b0;
      septets++;
      if (first_pending) begin
        res_bits = '0;
        res_cnt = fill;
        first_pending = 1'b0;
      end
      if (seen >= MaxSeptets) begin
        ovf = 1'b1;
      end else begin
        acc = {8'd0, res_bits} | ({8'd0, sep} << res_cnt);
        bits = res_cnt + 7;
        seen = seen + 8'd1;
        if (bits >= 8) begin
          done_r.octet = acc[7:0];
          res_bits = acc[14:8];
          res_cnt = bits - 8;
          have_done = emit_ok();
        end else begin
          res_bits = acc[6:0];
          res_cnt = bits;
        end
      end
      if (have_done) begin
        done_r.octet_valid = 1'b1;
        done_r.end_of_message = 1'b0;
        done_r.octet_count = sent;
        done_r.truncated = ovf;
      end
      if (!last) begin
        if (have_done) expected_octets.push_back(done_r);
        return;
      end
      messages++;
      flush_oct = res_bits;
      if (res_cnt > 0) have_flush = emit_ok();
      if (have_flush) begin
        if (have_done) expected_octets.push_back(done_r);
        r.octet = {1'b0, flush_oct};
        r.octet_valid = 1'b1;
        r.end_of_message = 1'b1;
        r.octet_count = sent;
        r.truncated = ovf;
        expected_octets.push_back(r);
      end else if (have_done) begin
        done_r.end_of_message = 1'b1;
        done_r.truncated = ovf;
        expected_octets.push_back(done_r);
      end else begin
        r.octet = 8'd0;
        r.octet_valid = 1'b0;
        r.end_of_message = 1'b1;
        r.octet_count = sent;
        r.truncated = ovf;
        expected_octets.push_back(r);
      end
      if (ovf) truncated_msgs++;
      res_bits = '0;
      res_cnt = 0;
      first_pending = 1'b1;
      seen = '0;
      sent = '0;
      ovf = 1'b0;
    endfunction

    function void report(string field, logic [7:0] exp_v, logic [7:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
    endfunction

    function void check_octet(result_t act);
      result_t exp_r;
      if (expected_octets.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, act);
        return;
      end
      exp_r = expected_octets.pop_front();
      results++;
      if (act.octet !== exp_r.octet) report("octet", exp_r.octet, act.octet);
      if (act.octet_valid !== exp_r.octet_valid)
        report("octet_valid", exp_r.octet_valid, act.octet_valid);
      if (act.end_of_message !== exp_r.end_of_message)
        report("end_of_message", exp_r.end_of_message, act.end_of_message);
      if (act.octet_count !== exp_r.octet_count)
        report("octet_count", exp_r.octet_count, act.octet_count);
      if (act.truncated !== exp_r.truncated)
        report("truncated", exp_r.truncated, act.truncated);
    endfunction
  endclass

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [7:0]  cfg_data_i;

  packer_model model;
  int          src_idle_pct;
  int          snk_idle_pct;
  bit          hold_request;
  int          hold_left;
  int          msg_left;
  int          quiet_cycles;

  gsm_septet_packer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left = HoldCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    result_t act;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act.octet = m_axis_tdata[7:0];
      act.octet_count = m_axis_tdata[15:8];
      act.end_of_message = m_axis_tlast;
      act.octet_valid = m_axis_tuser[0];
      act.truncated = m_axis_tuser[1];
      model.check_octet(act);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("%0t: no request accepted for %0d cycles", $time, WatchdogLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_septet(input logic [6:0] sep, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, sep};
    s_axis_tlast <= last;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    model.accept_septet(sep, last);
    @(negedge clk_i);
  endtask

  task automatic send_random_septet();
    int          r;
    logic [6:0]  sep;
    if (msg_left == 0) begin
      r = $urandom_range(99);
      if (r < 60) msg_left = $urandom_range(12, 1);
      else if (r < 90) msg_left = $urandom_range(60, 13);
      else msg_left = $urandom_range(175, 150);
    end
    r = $urandom_range(9);
    if (r == 0) sep = 7'h00;
    else if (r == 1) sep = 7'h7F;
    else sep = 7'($urandom_range(127));
    send_septet(sep, msg_left == 1);
    msg_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (model.pending() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic configure(input logic [2:0] fill, input logic [7:0] limit);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= RegFillBits;
    cfg_data_i <= {5'd0, fill};
    do @(posedge clk_i); while (!cfg_ready_o);
    model.write_reg(RegFillBits, {5'd0, fill});
    @(negedge clk_i);
    cfg_index_i <= RegOctetLimit;
    cfg_data_i <= limit;
    do @(posedge clk_i); while (!cfg_ready_o);
    model.write_reg(RegOctetLimit, limit);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [2:0] fill_sel;
    logic [7:0] limit_sel;
    model = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 8'd0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegFillBits;
    cfg_data_i = 8'd0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 1'b0;
    hold_left = 0;
    msg_left = 0;
    quiet_cycles = 0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_septet(7'h7F, 1'b1);
    send_septet(7'h00, 1'b0);
    send_septet(7'h7F, 1'b1);
    send_septet(7'h55, 1'b0);
    send_septet(7'h2A, 1'b0);
    send_septet(7'h7F, 1'b0);
    send_septet(7'h00, 1'b0);
    send_septet(7'h01, 1'b0);
    send_septet(7'h40, 1'b0);
    send_septet(7'h7F, 1'b0);
    send_septet(7'h33, 1'b1);
    drain();
    configure(3'd7, 8'd0);
    send_septet(7'h7F, 1'b0);
    send_septet(7'h7F, 1'b1);
    drain();
    configure(3'd7, 8'd255);
    send_septet(7'h7F, 1'b1);
    drain();
    configure(3'd6, 8'd2);
    send_septet(7'h01, 1'b0);
    send_septet(7'h7F, 1'b0);
    send_septet(7'h55, 1'b0);
    send_septet(7'h2A, 1'b1);
    drain();
    configure(3'd3, LimitReset);
    send_septet(7'h7F, 1'b0);
    send_septet(7'h00, 1'b0);
    drain();
    configure(3'd0, 8'd1);
    send_septet(7'h55, 1'b1);

    for (int b = 0; b < 12; b++) begin
      drain();
      if (b < 4) begin
        src_idle_pct = 33;
        snk_idle_pct = 87;
      end else if (b < 8) begin
        src_idle_pct = 87;
        snk_idle_pct = 33;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      case (b % 4)
        0: fill_sel = 3'd0;
        1: fill_sel = 3'd7;
        2: fill_sel = 3'd6;
        default: fill_sel = 3'($urandom_range(7));
      endcase
      case (b % 6)
        0: limit_sel = 8'd255;
        1: limit_sel = LimitReset;
        2: limit_sel = (b < 6) ? 8'd0 : 8'd1;
        3: limit_sel = 8'($urandom_range(30, 1));
        default: limit_sel = 8'($urandom_range(255));
      endcase
      configure(fill_sel, limit_sel);
      if (b == 8) hold_request = 1'b1;
      for (int k = 0; k < 120; k++) send_random_septet();
    end

    drain();
    repeat (20) @(negedge clk_i);
    $display("Covered %0d septets in %0d messages, %0d results checked.",
             model.septets, model.messages, model.results);
    $display("Messages with truncation: %0d; fill and limit changed across 17 settings.",
             model.truncated_msgs);
    if (model.errors == 0 && model.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
